// File: rtl/tso_pkg.sv
`timescale 1ns / 1ps
package tso_pkg;

  // Field widths
  localparam int IDX_W   = 15;
  localparam int TEX_W   = 15;
  localparam int MIP_W   = 4;
  localparam int PB_W    = 5;
  localparam int OFF_W   = 48;
  localparam int CNT_W   = 4;

  // Alignments (powers of two)
  localparam int PITCH_ALIGN = 256;
  localparam int PLACE_ALIGN = 512;

  // Row pitch: width * bytes plus one bit of rounding headroom
  localparam int PITCH_W = TEX_W + PB_W + 1;
  // Level footprint: pitch * height plus one bit of rounding headroom
  localparam int FP_W    = PITCH_W + TEX_W + 1;

  // Configuration port
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_MIP_COUNT   = 2'd2,
    REG_PIXEL_BYTES = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_width;
    logic [TEX_W-1:0] tex_height;
    logic [MIP_W-1:0] mip_count;
    logic [PB_W-1:0]  pixel_bytes;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LV_PITCH,
    S_LV_FOOT,
    S_LV_ACC,
    S_MUL,
    S_DONE
  } state_t;

endpackage

// File: rtl/tso_cfg.sv
`timescale 1ns / 1ps
module tso_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tso_pkg::ADDR_W-1:0]  paddr,
  input  logic [tso_pkg::DATA_W-1:0]  pwdata,
  output logic [tso_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tso_pkg::cfg_t               cfg
);
  import tso_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  // Register writes on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_width   <= TEX_W'(1);
      cfg_r.tex_height  <= TEX_W'(1);
      cfg_r.mip_count   <= MIP_W'(1);
      cfg_r.pixel_bytes <= PB_W'(4);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEX_WIDTH:   cfg_r.tex_width   <= pwdata[TEX_W-1:0];
        REG_TEX_HEIGHT:  cfg_r.tex_height  <= pwdata[TEX_W-1:0];
        REG_MIP_COUNT:   cfg_r.mip_count   <= pwdata[MIP_W-1:0];
        REG_PIXEL_BYTES: cfg_r.pixel_bytes <= pwdata[PB_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_TEX_WIDTH:   prdata = DATA_W'(cfg_r.tex_width);
      REG_TEX_HEIGHT:  prdata = DATA_W'(cfg_r.tex_height);
      REG_MIP_COUNT:   prdata = DATA_W'(cfg_r.mip_count);
      REG_PIXEL_BYTES: prdata = DATA_W'(cfg_r.pixel_bytes);
    endcase
  end

endmodule

// File: rtl/tso_foot.sv
`timescale 1ns / 1ps
module tso_foot (
  input  logic                           clk,
  input  tso_pkg::cfg_t                  cfg,
  input  logic [tso_pkg::CNT_W-1:0]      level,
  output logic [tso_pkg::FP_W-1:0]       footprint
);
  import tso_pkg::*;

  localparam logic [PITCH_W-1:0] PITCH_MASK = PITCH_W'(PITCH_ALIGN - 1);
  localparam logic [FP_W-1:0]    PLACE_MASK = FP_W'(PLACE_ALIGN - 1);

  logic [TEX_W-1:0]   w_sh;
  logic [TEX_W-1:0]   h_sh;
  logic [TEX_W-1:0]   w_lvl;
  logic [TEX_W-1:0]   h_lvl;
  logic [PITCH_W-1:0] row_bytes;
  logic [PITCH_W-1:0] pitch_nxt;
  logic [PITCH_W-1:0] pitch_r;
  logic [TEX_W-1:0]   h_r;
  logic [FP_W-1:0]    area;
  logic [FP_W-1:0]    fp_nxt;
  logic [FP_W-1:0]    fp_r;

  // Stage 1: level size with floor of one, aligned row pitch
  always_comb begin
    w_sh      = cfg.tex_width >> level;
    h_sh      = cfg.tex_height >> level;
    w_lvl     = (w_sh == '0) ? TEX_W'(1) : w_sh;
    h_lvl     = (h_sh == '0) ? TEX_W'(1) : h_sh;
    row_bytes = PITCH_W'(w_lvl) * PITCH_W'(cfg.pixel_bytes);
    pitch_nxt = (row_bytes + PITCH_MASK) & ~PITCH_MASK;
  end

  // Stage 2: pitch times height, aligned to placement
  always_comb begin
    area   = FP_W'(pitch_r) * FP_W'(h_r);
    fp_nxt = (area + PLACE_MASK) & ~PLACE_MASK;
  end

  always_ff @(posedge clk) begin
    pitch_r <= pitch_nxt;
    h_r     <= h_lvl;
    fp_r    <= fp_nxt;
  end

  assign footprint = fp_r;

endmodule

// File: rtl/texture_subresource_offset.sv
`timescale 1ns / 1ps
// Returns the byte offset of a subresource in a linear copy buffer. Pulse
// start while busy is low to hand over in_sub_index; busy then stays high
// until the result has been shown. out_byte_offset is valid for the single
// cycle in which out_valid is high, the last cycle with busy high, and the
// receiver must take it then. A query runs restoring division of the index
// by the mip count M, then passes each mip level through the two-stage
// footprint multiplier, then does shift-and-add for slice times chain size,
// and ends in a result state. The division, the footprint sums and the
// shift-and-add share one 48-bit adder. Write configuration only while busy
// is low.
module texture_subresource_offset (
  input  logic                          clk,
  input  logic                          rst_n,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [tso_pkg::IDX_W-1:0]     in_sub_index,
  // result side
  output logic                          out_valid,
  output logic [tso_pkg::OFF_W-1:0]     out_byte_offset,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tso_pkg::ADDR_W-1:0]    paddr,
  input  logic [tso_pkg::DATA_W-1:0]    pwdata,
  output logic [tso_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import tso_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IDX_W - 1);

  cfg_t             cfg;
  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] q_r;
  logic [MIP_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] lvl_r;
  logic [OFF_W-1:0] chain_r;
  logic [OFF_W-1:0] partial_r;
  logic [MIP_W-1:0] mips;
  logic [FP_W-1:0]  fp;
  logic             accept;

  // shared adder
  logic [OFF_W-1:0] add_a;
  logic [OFF_W-1:0] add_b;
  logic             add_cin;
  logic [OFF_W:0]   add_sum;
  logic             add_co;

  tso_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tso_foot u_foot (
    .clk       (clk),
    .cfg       (cfg),
    .level     (lvl_r),
    .footprint (fp)
  );

  // zero mip count behaves as one
  assign mips   = (cfg.mip_count == '0) ? MIP_W'(1) : cfg.mip_count;
  assign accept = start & ~busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (accept) state_nxt = S_DIV;
      S_DIV:      if (cnt_r == LAST_STEP) state_nxt = S_LV_PITCH;
      S_LV_PITCH: state_nxt = S_LV_FOOT;
      S_LV_FOOT:  state_nxt = S_LV_ACC;
      S_LV_ACC: begin
        if (lvl_r == CNT_W'(mips - MIP_W'(1))) state_nxt = S_MUL;
        else state_nxt = S_LV_PITCH;
      end
      S_MUL:      if (cnt_r == LAST_STEP) state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs and adder operand selection
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    add_a     = '0;
    add_b     = '0;
    add_cin   = 1'b0;
    unique case (state_r)
      S_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        add_a   = OFF_W'({rem_r, q_r[IDX_W-1]});
        add_b   = ~OFF_W'(mips);
        add_cin = 1'b1;
      end
      S_LV_ACC: begin
        add_a = chain_r;
        add_b = OFF_W'(fp);
      end
      S_MUL: begin
        add_a = partial_r;
        add_b = q_r[0] ? chain_r : '0;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (OFF_W + 1)'(add_cin);
  assign add_co  = add_sum[OFF_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          q_r       <= in_sub_index;
          rem_r     <= '0;
          cnt_r     <= '0;
          lvl_r     <= '0;
          chain_r   <= '0;
          partial_r <= '0;
        end
      end
      S_DIV: begin
        // quotient bit shifts in from the right; the difference becomes the remainder when no borrow
        q_r   <= {q_r[IDX_W-2:0], add_co};
        rem_r <= add_co ? add_sum[MIP_W-1:0] : {rem_r[MIP_W-2:0], q_r[IDX_W-1]};
        cnt_r <= (cnt_r == LAST_STEP) ? '0 : cnt_r + CNT_W'(1);
      end
      S_LV_ACC: begin
        // the partial sum is the chain before the remainder level is added
        if (lvl_r == CNT_W'(rem_r)) partial_r <= chain_r;
        chain_r <= add_sum[OFF_W-1:0];
        lvl_r   <= lvl_r + CNT_W'(1);
      end
      S_MUL: begin
        // shift-and-add of slice count times chain, into the partial sum
        partial_r <= add_sum[OFF_W-1:0];
        q_r       <= q_r >> 1;
        chain_r   <= chain_r << 1;
        cnt_r     <= cnt_r + CNT_W'(1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_byte_offset = partial_r;

`ifndef SYNTH
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy still high after result");

  a_result_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy && $past(busy))
    else $error("result shown without a query in flight");

  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LV_PITCH && $past(state_r) == S_DIV) |-> (rem_r < mips))
    else $error("division remainder not below mip count");

  a_lvl_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LV_ACC) |-> (lvl_r < CNT_W'(mips)))
    else $error("mip level beyond mip count");
`endif

endmodule

// File: verif/tso_offset_checker.sv
`timescale 1ns / 1ps
// Watches the command, result and register ports of the subresource offset
// unit. Keeps a shadow of the registers, predicts the byte offset of every
// accepted query and compares each result with the oldest prediction.
module tso_offset_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [tso_pkg::IDX_W-1:0]  sub_index,
  input  logic                       out_valid,
  input  logic [tso_pkg::OFF_W-1:0]  byte_offset,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tso_pkg::ADDR_W-1:0] paddr,
  input  logic [tso_pkg::DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending,
  output int                         checked
);
  import tso_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] offset;
  } query_t;

  cfg_t   shadow_cfg;
  query_t offsets_due[$];
  query_t oldest;

  // Sum of the aligned footprints of every subresource below idx
  function automatic logic [OFF_W-1:0] subresource_offset(input cfg_t c,
                                                          input logic [IDX_W-1:0] idx);
    logic [63:0] chain_bytes;
    logic [63:0] head_bytes;
    logic [63:0] lw;
    logic [63:0] lh;
    logic [63:0] pitch;
    logic [63:0] foot;
    int unsigned mips;
    int unsigned slices;
    int unsigned rest;
    chain_bytes = 0;
    head_bytes  = 0;
    mips   = (c.mip_count == 0) ? 1 : c.mip_count;
    slices = idx / mips;
    rest   = idx % mips;
    for (int lv = 0; lv < mips; lv++) begin
      lw = 64'(c.tex_width) >> lv;
      lh = 64'(c.tex_height) >> lv;
      if (lw == 0) lw = 1;
      if (lh == 0) lh = 1;
      pitch = ((lw * c.pixel_bytes + PITCH_ALIGN - 1) / PITCH_ALIGN) * PITCH_ALIGN;
      foot  = ((pitch * lh + PLACE_ALIGN - 1) / PLACE_ALIGN) * PLACE_ALIGN;
      if (lv < rest) head_bytes += foot;
      chain_bytes += foot;
    end
    return OFF_W'(64'(slices) * chain_bytes + head_bytes);
  endfunction

  // One line per mismatch; printing is capped, counting is not
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg.tex_width   = 1;
      shadow_cfg.tex_height  = 1;
      shadow_cfg.mip_count   = 1;
      shadow_cfg.pixel_bytes = 4;
      offsets_due.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      // result transfer
      if (out_valid) begin
        if (offsets_due.size() == 0) begin
          report_mismatch($sformatf("result 0x%012h with no query outstanding",
                                    byte_offset));
        end else begin
          oldest = offsets_due.pop_front();
          checked++;
          if (byte_offset !== oldest.offset)
            report_mismatch($sformatf("index %0d: offset 0x%012h, predicted 0x%012h",
                                      oldest.idx, byte_offset, oldest.offset));
        end
      end
      // command transfer
      if (start && !busy)
        offsets_due.push_back('{idx: sub_index,
                                offset: subresource_offset(shadow_cfg, sub_index)});
      // register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_TEX_WIDTH:   shadow_cfg.tex_width   = pwdata[TEX_W-1:0];
          REG_TEX_HEIGHT:  shadow_cfg.tex_height  = pwdata[TEX_W-1:0];
          REG_MIP_COUNT:   shadow_cfg.mip_count   = pwdata[MIP_W-1:0];
          REG_PIXEL_BYTES: shadow_cfg.pixel_bytes = pwdata[PB_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= offsets_due.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the subresource offset unit: directed register
// settings and indices first, then random settings with random queries.
module tb;
  import tso_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [IDX_W-1:0]  in_sub_index = '0;
  logic              out_valid;
  logic [OFF_W-1:0]  out_byte_offset;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int checked;
  int n_queries = 0;
  int n_setups  = 0;
  bit idle_on   = 1'b1;

  texture_subresource_offset dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_sub_index(in_sub_index),
    .out_valid(out_valid), .out_byte_offset(out_byte_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tso_offset_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sub_index(in_sub_index), .out_valid(out_valid), .byte_offset(out_byte_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Setup and access phase of one register write, then back to idle
  task automatic reg_write(input reg_idx_t r, input logic [DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Block until every predicted offset has come back and the unit is free
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic load_setup(input int w, input int h, input int m, input int pb);
    wait_drained();
    reg_write(REG_TEX_WIDTH, w);
    reg_write(REG_TEX_HEIGHT, h);
    reg_write(REG_MIP_COUNT, m);
    reg_write(REG_PIXEL_BYTES, pb);
    n_setups++;
  endtask

  // One command transfer, then maybe a gap with start low
  task automatic query(input int idx);
    start        <= 1'b1;
    in_sub_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (busy);
    n_queries++;
    if (idle_on && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
  endtask

  function automatic int rand_size();
    case ($urandom_range(0, 3))
      0:       return 1 << $urandom_range(0, 14);
      1:       return $urandom_range(1, 16384);
      2:       return $urandom_range(0, 32767);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int rand_pixel_bytes();
    case ($urandom_range(0, 2))
      0:       return 1 << $urandom_range(0, 4);
      1:       return $urandom_range(1, 16);
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    int defaults_idx[4] = '{0, 1, 2, 32767};
    int extreme_idx[9]  = '{0, 1, 14, 15, 16, 16383, 21845, 10922, 32767};
    int zero_idx[3]     = '{0, 5, 32767};
    int tall_idx[4]     = '{0, 14, 15, 32767};
    int nomip_idx[2]    = '{7, 32767};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers
    foreach (defaults_idx[i]) query(defaults_idx[i]);
    // Every field at its top: the largest offsets, which still fit in 48 bits
    load_setup(32767, 32767, 15, 31);
    foreach (extreme_idx[i]) query(extreme_idx[i]);
    // Zero sizes, zero mip count and zero pixel bytes
    load_setup(0, 0, 0, 0);
    foreach (zero_idx[i]) query(zero_idx[i]);
    // Wide single-row texture with a full mip chain
    load_setup(16384, 1, 15, 16);
    foreach (tall_idx[i]) query(tall_idx[i]);
    // Zero mip count with ordinary sizes
    load_setup(100, 37, 0, 3);
    foreach (nomip_idx[i]) query(nomip_idx[i]);

    // Random settings, each with a burst of random queries
    for (int ph = 0; ph < 10; ph++) begin
      load_setup(rand_size(), rand_size(),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15),
                 rand_pixel_bytes());
      idle_on = (ph != 4);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0) query($urandom_range(0, 63));
        else query($urandom_range(0, 32767));
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Sent %0d offset queries over %0d register settings; %0d results compared.",
             n_queries, n_setups + 1, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d offsets still awaited", mismatches, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tso_pkg.sv
rtl/tso_cfg.sv
rtl/tso_foot.sv
rtl/texture_subresource_offset.sv
verif/tso_offset_checker.sv
verif/tb.sv
